/* rtl/pbbd_pkg.sv */
// Package: shared types, constants and the color lookup for the mesh body decoder.
package pbbd_pkg;

    localparam int VtxWidth  = 16;
    localparam int FaceWidth = 24;
    localparam int QueueDepth = 4;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_INDEX  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] REG_VERTEX_TOTAL = 3'd0;
    localparam logic [2:0] REG_FACE_TOTAL   = 3'd1;
    localparam logic [2:0] REG_HAS_UV       = 3'd2;
    localparam logic [2:0] REG_HAS_COLOR    = 3'd3;
    localparam logic [2:0] REG_ADD_TANGENT  = 3'd4;

    // Work descriptor from front to back.
    typedef enum logic [1:0] {
        OP_WORD  = 2'd0,
        OP_TRI   = 2'd1,
        OP_QUAD  = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [1:0]  kind;
        logic [31:0] word;
        logic        tangent;
        logic        done;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
    } t_job;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word;
        logic        run_last;
        logic        body_done;
    } t_result;

    typedef logic [255:0][31:0] t_color_lut;

    // Nearest float32 to b/255, exact integer rounding (evaluated only to build the table).
    function automatic logic [31:0] color_bits(input logic [7:0] b);
        logic [4:0]  s;
        logic [63:0] n;
        logic [63:0] q;
        logic [63:0] r;
        logic [31:0] res;
        s = 5'd0;
        res = 32'd0;
        if (b == 8'd0) begin
            res = 32'd0;
        end else if (b == 8'd255) begin
            res = 32'h3F80_0000;
        end else begin
            for (int i = 0; i < 8; i++) begin
                if (({24'd0, b} << s) < 32'd255) s = s + 5'd1;
            end
            n = {56'd0, b} << (6'd23 + {1'b0, s});
            q = n / 64'd255;
            r = n % 64'd255;
            if ((r << 1) > 64'd255) q = q + 64'd1;
            res = ({27'd0, 5'd0} + ((32'd127 - {27'd0, s}) << 23)) + (q[31:0] - 32'h0080_0000);
        end
        return res;
    endfunction

    // Full byte-to-float color table.
    function automatic t_color_lut build_color_lut();
        t_color_lut lut;
        for (int i = 0; i < 256; i++) lut[i] = color_bits(8'(i));
        return lut;
    endfunction

    localparam t_color_lut ColorLut = build_color_lut();

endpackage

/* rtl/pbbd_if.sv */
// Valid/ready stream interfaces for bytes, results and configuration writes.
interface pbbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pbbd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] word;
    logic        run_last;
    logic        body_done;
    modport source (output valid, output kind, output word, output run_last,
                    output body_done, input ready);
    modport sink   (input valid, input kind, input word, input run_last,
                    input body_done, output ready);
endinterface

interface pbbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/ply_binary_body_decoder.sv */
// Top level: config registers, byte front end and result back end.
// A completed word or face becomes a job registered in the back-end queue.
// Throughput: one byte per cycle; each job drains 1, 3, 5 or 6 results at one per cycle
// while out_ch is ready, through a 4-entry job queue; bytes stall only when it is full.
// Reset: synchronous active-low; clears parser state, queue and config registers.
module ply_binary_body_decoder #(
    parameter int VW = pbbd_pkg::VtxWidth,
    parameter int FW = pbbd_pkg::FaceWidth,
    parameter int DEPTH = pbbd_pkg::QueueDepth
) (
    input logic i_clk,
    input logic i_rst_n,
    pbbd_byte_if.sink  in_ch,
    pbbd_cfg_if.sink   cfg_ch,
    pbbd_res_if.source out_ch
);

    logic [VW-1:0] r_vtot;
    logic [FW-1:0] r_ftot;
    logic r_uv, r_col, r_tan;
    logic job_valid, job_ready;
    pbbd_pkg::t_job job;
    pbbd_pkg::t_result res;

    assign cfg_ch.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtot <= '0;
            r_ftot <= '0;
            r_uv <= 1'b0;
            r_col <= 1'b0;
            r_tan <= 1'b0;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                pbbd_pkg::REG_VERTEX_TOTAL: r_vtot <= cfg_ch.data[VW-1:0];
                pbbd_pkg::REG_FACE_TOTAL:   r_ftot <= cfg_ch.data[FW-1:0];
                pbbd_pkg::REG_HAS_UV:       r_uv <= cfg_ch.data[0];
                pbbd_pkg::REG_HAS_COLOR:    r_col <= cfg_ch.data[0];
                pbbd_pkg::REG_ADD_TANGENT:  r_tan <= cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    pbbd_front #(.VW(VW), .FW(FW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .i_byte(in_ch.data_byte), .o_ready(in_ch.ready),
        .i_vertex_total(r_vtot), .i_face_total(r_ftot),
        .i_has_uv(r_uv), .i_has_color(r_col), .i_add_tangent(r_tan),
        .o_job_valid(job_valid), .o_job(job), .i_job_ready(job_ready)
    );

    pbbd_back #(.DEPTH(DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .i_job(job), .o_job_ready(job_ready),
        .o_valid(out_ch.valid), .o_res(res), .i_ready(out_ch.ready)
    );

    assign out_ch.kind = res.kind;
    assign out_ch.word = res.word;
    assign out_ch.run_last = res.run_last;
    assign out_ch.body_done = res.body_done;

endmodule

/* rtl/pbbd_front.sv */
// Front end: byte parser that classifies each byte and issues back-end jobs.
module pbbd_front #(
    parameter int VW = pbbd_pkg::VtxWidth,
    parameter int FW = pbbd_pkg::FaceWidth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_ready,
    input  logic [VW-1:0]   i_vertex_total,
    input  logic [FW-1:0]   i_face_total,
    input  logic            i_has_uv,
    input  logic            i_has_color,
    input  logic            i_add_tangent,
    output logic            o_job_valid,
    output pbbd_pkg::t_job  o_job,
    input  logic            i_job_ready
);

    typedef enum logic [3:0] {
        PH_VERTEX = 4'b0001,
        PH_FACE   = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_HALT   = 4'b1000
    } t_phase;

    t_phase        r_phase;
    logic [VW-1:0] r_vcnt;
    logic [3:0]    r_comp;
    logic [1:0]    r_bpos;
    logic [23:0]   r_part;
    logic [FW-1:0] r_fcnt;
    logic [2:0]    r_ctot;
    logic [1:0]    r_cidx;
    logic [15:0]   r_cs [4];

    t_phase        n_phase;
    logic [VW-1:0] n_vcnt;
    logic [3:0]    n_comp;
    logic [1:0]    n_bpos;
    logic [23:0]   n_part;
    logic [FW-1:0] n_fcnt;
    logic [2:0]    n_ctot;
    logic [1:0]    n_cidx;
    logic          cs_we;
    logic          take;
    t_phase        eff;
    logic          emit;
    pbbd_pkg::t_job job;
    logic [3:0]    nxt;
    logic [15:0]   idx;

    assign o_ready = i_job_ready;
    assign take = i_valid && o_ready;
    assign idx = {i_byte, r_part[7:0]};

    // Next vertex component under the current flags.
    always_comb begin
        case (r_comp)
            4'd5:    nxt = i_has_uv ? 4'd6 : (i_has_color ? 4'd8 : 4'd0);
            4'd7:    nxt = i_has_color ? 4'd8 : 4'd0;
            4'd10:   nxt = 4'd0;
            default: nxt = r_comp + 4'd1;
        endcase
    end

    // Byte classification.
    always_comb begin
        eff = r_phase;
        if (eff == PH_VERTEX && r_vcnt >= i_vertex_total) eff = PH_FACE;
        if (eff == PH_FACE && r_ctot == 3'd0 && r_fcnt >= i_face_total) eff = PH_DONE;
        n_phase = eff;
        n_vcnt = r_vcnt;
        n_comp = r_comp;
        n_bpos = r_bpos;
        n_part = r_part;
        n_fcnt = r_fcnt;
        n_ctot = r_ctot;
        n_cidx = r_cidx;
        cs_we = 1'b0;
        emit = 1'b0;
        job = '0;
        job.op = pbbd_pkg::OP_WORD;
        job.kind = pbbd_pkg::KIND_VERTEX;
        job.c0 = r_cs[0];
        job.c1 = r_cs[1];
        job.c2 = r_cs[2];
        job.c3 = idx;
        case (eff)
            PH_VERTEX: begin
                if (r_comp >= 4'd8 || r_bpos == 2'd3) begin
                    emit = 1'b1;
                    job.word = (r_comp >= 4'd8) ? pbbd_pkg::ColorLut[i_byte]
                                                : {i_byte, r_part};
                    job.tangent = (r_comp == 4'd5) && i_add_tangent;
                    if (r_comp < 4'd8) begin
                        n_part = '0;
                        n_bpos = 2'd0;
                    end
                    n_comp = nxt;
                    if (nxt == 4'd0) n_vcnt = r_vcnt + 1'b1;
                end else begin
                    case (r_bpos)
                        2'd0:    n_part[7:0] = i_byte;
                        2'd1:    n_part[15:8] = i_byte;
                        default: n_part[23:16] = i_byte;
                    endcase
                    n_bpos = r_bpos + 2'd1;
                end
            end
            PH_FACE: begin
                if (r_ctot == 3'd0) begin
                    if (i_byte == 8'd3 || i_byte == 8'd4) begin
                        n_ctot = i_byte[2:0];
                        n_cidx = 2'd0;
                        n_bpos = 2'd0;
                        n_part = '0;
                    end else begin
                        emit = 1'b1;
                        job.kind = pbbd_pkg::KIND_ERROR;
                        job.word = {24'd0, i_byte};
                        n_phase = PH_HALT;
                    end
                end else if (r_bpos == 2'd0) begin
                    n_part = {16'd0, i_byte};
                    n_bpos = 2'd1;
                end else begin
                    cs_we = 1'b1;
                    n_part = '0;
                    n_bpos = 2'd0;
                    n_cidx = r_cidx + 2'd1;
                    if ({1'b0, r_cidx} + 3'd1 >= r_ctot) begin
                        emit = 1'b1;
                        job.kind = pbbd_pkg::KIND_INDEX;
                        job.op = (r_ctot == 3'd3) ? pbbd_pkg::OP_TRI : pbbd_pkg::OP_QUAD;
                        if (r_ctot == 3'd3) job.c2 = idx;
                        job.done = ({1'b0, r_fcnt} + 1'b1) >= {1'b0, i_face_total};
                        n_fcnt = r_fcnt + 1'b1;
                        n_ctot = 3'd0;
                        n_cidx = 2'd0;
                        if (job.done) n_phase = PH_DONE;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_job_valid = take && emit;
    assign o_job = job;

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VERTEX;
            r_vcnt <= '0;
            r_comp <= '0;
            r_bpos <= '0;
            r_part <= '0;
            r_fcnt <= '0;
            r_ctot <= '0;
            r_cidx <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_vcnt <= n_vcnt;
            r_comp <= n_comp;
            r_bpos <= n_bpos;
            r_part <= n_part;
            r_fcnt <= n_fcnt;
            r_ctot <= n_ctot;
            r_cidx <= n_cidx;
        end
    end

    // Corner store.
    always_ff @(posedge i_clk) begin
        if (take && cs_we) r_cs[r_cidx] <= idx;
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT) else $error("halt left");
    a_ctot_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctot == 3'd0 || r_ctot == 3'd3 || r_ctot == 3'd4) else $error("bad ctot");
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && o_job.kind == pbbd_pkg::KIND_ERROR |=> r_phase == PH_HALT)
        else $error("error without halt");

endmodule

/* rtl/pbbd_back.sv */
// Back end: job queue and sequencer that expands jobs into result words.
module pbbd_back #(
    parameter int DEPTH = pbbd_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  pbbd_pkg::t_job  i_job,
    output logic            o_job_ready,
    output logic            o_valid,
    output pbbd_pkg::t_result o_res,
    input  logic            i_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pbbd_pkg::t_job r_q [DEPTH];
    logic [AW-1:0]  r_rd, r_wr;
    logic [AW:0]    r_cnt;
    logic [2:0]     r_sub;
    pbbd_pkg::t_job head;
    logic [2:0]     nres;
    logic           pop, push, last;

    assign head = r_q[r_rd];
    assign push = i_job_valid;
    assign o_job_ready = (r_cnt != DEPTH[AW:0]);
    assign o_valid = (r_cnt != '0);

    // Result count per job.
    always_comb begin
        case (head.op)
            pbbd_pkg::OP_TRI:  nres = 3'd3;
            pbbd_pkg::OP_QUAD: nres = 3'd6;
            default:           nres = head.tangent ? 3'd5 : 3'd1;
        endcase
    end

    assign last = (r_sub == nres - 3'd1);
    assign pop = o_valid && i_ready && last;

    // Pick the word for this slot.
    always_comb begin
        o_res.kind = head.kind;
        o_res.run_last = last;
        o_res.body_done = last && head.done;
        o_res.word = head.word;
        if (head.op == pbbd_pkg::OP_WORD) begin
            if (r_sub != 3'd0) o_res.word = '0;
        end else begin
            case (r_sub)
                3'd0:    o_res.word = {16'd0, head.c0};
                3'd1:    o_res.word = {16'd0, head.c1};
                3'd2:    o_res.word = {16'd0, head.c2};
                3'd3:    o_res.word = {16'd0, head.c2};
                3'd4:    o_res.word = {16'd0, head.c3};
                default: o_res.word = {16'd0, head.c0};
            endcase
        end
    end

    // Queue pointers and slot counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
            r_cnt <= '0;
            r_sub <= '0;
        end else begin
            if (push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (pop) r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
            if (o_valid && i_ready) r_sub <= last ? 3'd0 : r_sub + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> o_job_ready) else $error("queue overflow");
    a_sub_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> r_sub == 3'd0) else $error("slot counter busy while empty");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.body_done |-> o_res.run_last) else $error("done not last");

endmodule
